// File: sv/csp_pkg.sv
// Package for the contrast and sepia pixel pipeline: field widths, sepia
// coefficients, divide-by-1000 reciprocal constants and shared types.
// No dependencies.
package csp_pkg;

	// Field widths
	localparam int COMP_W      = 8;
	localparam int GAIN_W      = 15;
	localparam int GAIN_FRAC   = 12;
	localparam int PROD_W      = COMP_W + GAIN_W;

	// Largest component value and gain after reset (about 1.1025 in Q3.12)
	localparam logic [COMP_W-1:0] COMP_MAX   = 8'd255;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd4516;

	// Sepia matrix in units of 1/1000, one row per output component
	localparam int COEF_W = 10;
	localparam logic [COEF_W-1:0] SEPIA_MILLI [3][3] = '{
		'{10'd393, 10'd769, 10'd189},
		'{10'd349, 10'd686, 10'd168},
		'{10'd272, 10'd534, 10'd131}
	};

	// Row sum: 255 * 1351 fits in 19 bits
	localparam int SUM_W = 19;

	// Divide by 1000 as multiply by ceil(2^28 / 1000) and shift; exact for
	// every sum below the clamp limit (255 + 1) * 1000, which fits in 18 bits
	localparam int                  SEPIA_SCALE = 1000;
	localparam logic [SUM_W-1:0]    DIV_LIMIT   = SUM_W'((int'(COMP_MAX) + 1) * SEPIA_SCALE);
	localparam int                  QIN_W       = 18;
	localparam int                  DIV_SHIFT   = 28;
	localparam int                  DMUL_W      = 19;
	localparam logic [DMUL_W-1:0]   DIV_MUL     = 19'd268436;
	localparam int                  QPROD_W     = QIN_W + DMUL_W;

	// Load strobes for the two stages inside a sepia row
	typedef struct packed {
		logic s3;
		logic s4;
	} csp_row_en_t;

endpackage

// File: sv/csp_in_if.sv
// Source pixel channel: valid/ready handshake with three 8-bit components.
// Depends on csp_pkg.
interface csp_in_if import csp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [COMP_W-1:0] red_in;
	logic [COMP_W-1:0] green_in;
	logic [COMP_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink   (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

// File: sv/csp_out_if.sv
// Sepia pixel channel: valid/ready handshake with three 8-bit components.
// Depends on csp_pkg.
interface csp_out_if import csp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [COMP_W-1:0] red_out;
	logic [COMP_W-1:0] green_out;
	logic [COMP_W-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

// File: sv/csp_sepia_row.sv
// One row of the sepia matrix: weighted sum of the scaled components (stage 3),
// then divide by 1000 and clamp (stage 4). Depends on csp_pkg.
module csp_sepia_row import csp_pkg::*; #(
	parameter int ROW = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csp_row_en_t       en,
	input  logic [COMP_W-1:0] scaled [3],
	output logic [COMP_W-1:0] res_s4
);

	logic [SUM_W-1:0]   sum_d;
	logic [SUM_W-1:0]   sum_s3;
	logic [QPROD_W-1:0] qprod;
	logic [COMP_W-1:0]  quo;
	logic               over;

	// Weighted sum of the three scaled components
	always_comb begin
		sum_d = SUM_W'(scaled[0]) * SUM_W'(SEPIA_MILLI[ROW][0])
			+ SUM_W'(scaled[1]) * SUM_W'(SEPIA_MILLI[ROW][1])
			+ SUM_W'(scaled[2]) * SUM_W'(SEPIA_MILLI[ROW][2]);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= sum_d;
		end
	end

	// Divide by 1000 through the reciprocal; saturate at the clamp limit
	always_comb begin
		over  = (sum_s3 >= DIV_LIMIT);
		qprod = QPROD_W'(sum_s3[QIN_W-1:0]) * QPROD_W'(DIV_MUL);
		quo   = qprod[DIV_SHIFT +: COMP_W];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4 <= over ? COMP_MAX : quo;
		end
	end

	// Saturated sums give the maximum, sums below one unit give zero
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		en.s4 && (sum_s3 >= DIV_LIMIT) |=> res_s4 == COMP_MAX)
		else $error("sepia row did not saturate");
	a_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en.s4 && (sum_s3 < SUM_W'(SEPIA_SCALE)) |=> res_s4 == '0)
		else $error("sepia row below one unit is not zero");

endmodule

// File: sv/contrast_sepia_pixel_unit.sv
// Contrast gain and sepia tone, one pixel per cycle unless pix_out stalls, four register stages.
// Depends on csp_pkg, csp_in_if, csp_out_if and csp_sepia_row.
//
// Usage:
//   pix_in carries one RGB word (8-bit red_in, green_in, blue_in); a word is
//   taken at a clock edge with valid and ready high. pix_out carries the
//   sepia word (red_out, green_out, blue_out) under the same handshake.
//   gain_we/gain_wdata write the contrast gain (unsigned Q3.12, 4096 = 1.0);
//   write it only while no word is in flight.
// Timing:
//   Stage 1 multiplies by the gain, stage 2 clamps, stage 3 forms the three
//   sepia row sums, stage 4 divides by 1000 and clamps. A taken word is
//   registered in stages 1 to 4 in order and shown on pix_out from stage 4.
//   One word per cycle is sustained while pix_out is ready; each stage holds
//   its own valid bit, so bubbles close up behind a stalled output.
// Reset:
//   arst_n clears all stage valid bits and sets the gain to 4516.
// Stall:
//   While pix_out.ready is low the output word holds and earlier stages
//   keep filling; pix_in.ready drops only when every stage is full.
module contrast_sepia_pixel_unit import csp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	csp_in_if.sink            pix_in,
	csp_out_if.source         pix_out,
	input  logic              gain_we,
	input  logic [GAIN_W-1:0] gain_wdata
);

	logic [GAIN_W-1:0] gain_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [PROD_W-1:0] prod_s1 [3];
	logic [COMP_W-1:0] scaled_s2 [3];
	logic [COMP_W-1:0] comp_in [3];
	logic [COMP_W-1:0] res_s4 [3];
	logic [PROD_W-GAIN_FRAC-1:0] shifted [3];
	csp_row_en_t row_en;

	// Hold the contrast gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (gain_we) begin
			gain_q <= gain_wdata;
		end
	end

	// Advance a stage when it is empty or its successor advances
	assign rdy4 = !valid_s4 || pix_out.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= pix_in.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	assign comp_in[0] = pix_in.red_in;
	assign comp_in[1] = pix_in.green_in;
	assign comp_in[2] = pix_in.blue_in;

	// Stage 1: scale each component by the gain
	always_ff @(posedge clk) begin
		if (rdy1 && pix_in.valid) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[c] <= PROD_W'(comp_in[c]) * PROD_W'(gain_q);
			end
		end
	end

	// Stage 2: drop the fraction and clamp
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			shifted[c] = prod_s1[c][PROD_W-1:GAIN_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			for (int c = 0; c < 3; c++) begin
				scaled_s2[c] <= (shifted[c] > (PROD_W-GAIN_FRAC)'(COMP_MAX)) ?
					COMP_MAX : shifted[c][COMP_W-1:0];
			end
		end
	end

	// Stages 3 and 4: sepia rows
	assign row_en.s3 = rdy3 && valid_s2;
	assign row_en.s4 = rdy4 && valid_s3;

	for (genvar r = 0; r < 3; r++) begin : g_row
		csp_sepia_row #(
			.ROW(r)
		) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (row_en),
			.scaled (scaled_s2),
			.res_s4 (res_s4[r])
		);
	end

	assign pix_out.valid     = valid_s4;
	assign pix_out.red_out   = res_s4[0];
	assign pix_out.green_out = res_s4[1];
	assign pix_out.blue_out  = res_s4[2];

	// A taken word enters stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> valid_s1)
		else $error("accepted word missing from stage 1");
	// A blocked stage 1 stays valid and keeps its red and blue products
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rdy2 |=> valid_s1 && $stable(prod_s1[0]) && $stable(prod_s1[2]))
		else $error("stage 1 word changed while blocked");
	// Zero gain gives zero products
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready && (gain_q == '0) |=>
		(prod_s1[0] == '0) && (prod_s1[1] == '0) && (prod_s1[2] == '0))
		else $error("nonzero product with zero gain");
	// A word leaving stage 3 lands in the output stage
	a_s4_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && rdy4 |=> valid_s4)
		else $error("stage 3 word lost");

endmodule

// File: verif/tb_contrast_sepia_pixel_unit.sv
// Self-checking bench for contrast_sepia_pixel_unit: random bursts of pixel words
// against a stalling receiver, compared with an inline contrast and sepia predictor.
// Depends on csp_pkg, csp_in_if, csp_out_if and contrast_sepia_pixel_unit.
module tb_contrast_sepia_pixel_unit import csp_pkg::*;;

	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned RANDOM_PER_SET = 55;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 15'd4096;
	localparam logic [GAIN_W-1:0] GAIN_TOP   = 15'd16384;
	localparam logic [GAIN_W-1:0] GAIN_FULL  = 15'd32767;
	localparam int unsigned MILLI = 1000;

	// Sepia weights in thousandths, one row per output component
	localparam int unsigned SEPIA_WEIGHT [3][3] = '{
		'{393, 769, 189},
		'{349, 686, 168},
		'{272, 534, 131}
	};

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} pixel_t;

	logic              clk;
	logic              arst_n;
	logic              gain_we;
	logic [GAIN_W-1:0] gain_wdata;

	csp_in_if  pix_in_bus ();
	csp_out_if pix_out_bus ();

	contrast_sepia_pixel_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in_bus),
		.pix_out   (pix_out_bus),
		.gain_we   (gain_we),
		.gain_wdata(gain_wdata)
	);

	pixel_t            pixel_q[$];
	pixel_t            sepia_q[$];
	logic [GAIN_W-1:0] gain_now;
	int unsigned       fail_count;
	int unsigned       cycle_count;
	int unsigned       burst_left;
	int unsigned       gap_left;
	logic [15:0]       stall_pattern;
	int unsigned       stall_pos;

	// Scale by the gain, clamp, then run the sepia matrix on the scaled word
	function automatic pixel_t sepia_of(logic [GAIN_W-1:0] gain, pixel_t px);
		int unsigned src [3];
		int unsigned scaled [3];
		int unsigned acc;
		int unsigned row_val [3];
		pixel_t      res;
		src = '{px.red, px.green, px.blue};
		for (int c = 0; c < 3; c++) begin
			scaled[c] = (src[c] * gain) >> GAIN_FRAC;
			if (scaled[c] > 255) scaled[c] = 255;
		end
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++) acc += scaled[c] * SEPIA_WEIGHT[r][c];
			row_val[r] = acc / MILLI;
			if (row_val[r] > 255) row_val[r] = 255;
		end
		res.red   = row_val[0][COMP_W-1:0];
		res.green = row_val[1][COMP_W-1:0];
		res.blue  = row_val[2][COMP_W-1:0];
		return res;
	endfunction

	// Favor the rails so clamping is hit often
	function automatic logic [COMP_W-1:0] pick_component();
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return COMP_W'($urandom);
	endfunction

	function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b);
		pixel_t px;
		px.red   = COMP_W'(r);
		px.green = COMP_W'(g);
		px.blue  = COMP_W'(b);
		return px;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Driver: send words from pixel_q in bursts, hold a word until taken
	always @(posedge clk or negedge arst_n) begin : drive_blk
		int unsigned burst_n;
		int unsigned gap_n;
		pixel_t      word;
		if (!arst_n) begin
			pix_in_bus.valid    <= 1'b0;
			pix_in_bus.red_in   <= '0;
			pix_in_bus.green_in <= '0;
			pix_in_bus.blue_in  <= '0;
			burst_left          <= 0;
			gap_left            <= 0;
		end else begin
			burst_n = burst_left;
			gap_n   = gap_left;
			if (pix_in_bus.valid && pix_in_bus.ready) begin
				word.red   = pix_in_bus.red_in;
				word.green = pix_in_bus.green_in;
				word.blue  = pix_in_bus.blue_in;
				sepia_q.push_back(sepia_of(gain_now, word));
			end
			if (!(pix_in_bus.valid && !pix_in_bus.ready)) begin
				if (burst_n == 0 && gap_n == 0) begin
					burst_n = $urandom_range(1, 24);
					gap_n   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (burst_n > 0 && pixel_q.size() > 0) begin
					word = pixel_q.pop_front();
					pix_in_bus.valid    <= 1'b1;
					pix_in_bus.red_in   <= word.red;
					pix_in_bus.green_in <= word.green;
					pix_in_bus.blue_in  <= word.blue;
					burst_n--;
				end else begin
					pix_in_bus.valid <= 1'b0;
					if (burst_n == 0 && gap_n > 0) gap_n--;
				end
			end
			burst_left <= burst_n;
			gap_left   <= gap_n;
		end
	end

	// Receiver: step through a 16-bit ready pattern, reload it at each wrap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out_bus.ready <= 1'b0;
			stall_pattern     <= '1;
			stall_pos         <= 0;
		end else begin
			pix_out_bus.ready <= stall_pattern[stall_pos];
			if (stall_pos == 15) begin
				stall_pos     <= 0;
				stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			end else begin
				stall_pos <= stall_pos + 1;
			end
		end
	end

	// Monitor: compare each taken result word with the oldest prediction
	always @(posedge clk) begin : check_blk
		pixel_t want;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			if (sepia_q.size() == 0) begin
				$error("unexpected result word r=%0d g=%0d b=%0d", pix_out_bus.red_out,
					pix_out_bus.green_out, pix_out_bus.blue_out);
				fail_count++;
			end else begin
				want = sepia_q.pop_front();
				if (pix_out_bus.red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, pix_out_bus.red_out);
					fail_count++;
				end
				if (pix_out_bus.green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green,
						pix_out_bus.green_out);
					fail_count++;
				end
				if (pix_out_bus.blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, pix_out_bus.blue_out);
					fail_count++;
				end
			end
		end
	end

	// Wait until every word is sent and every result has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_q.size() != 0 || pix_in_bus.valid || sepia_q.size() != 0);
	endtask

	task automatic write_gain(logic [GAIN_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		gain_we    <= 1'b1;
		gain_wdata <= value;
		@(posedge clk);
		gain_we    <= 1'b0;
		gain_now    = value;
	endtask

	// Queue rail corners and a batch of random words under the current gain
	task automatic queue_set(int unsigned n_random);
		@(negedge clk);
		pixel_q.push_back(make_pixel(0, 0, 0));
		pixel_q.push_back(make_pixel(255, 255, 255));
		pixel_q.push_back(make_pixel(255, 0, 0));
		pixel_q.push_back(make_pixel(0, 255, 0));
		pixel_q.push_back(make_pixel(0, 0, 255));
		for (int i = 0; i < n_random; i++)
			pixel_q.push_back(make_pixel(pick_component(), pick_component(),
				pick_component()));
	endtask

	// Stimulus and end of run
	initial begin
		arst_n              = 1'b0;
		gain_we             = 1'b0;
		gain_wdata          = '0;
		pix_in_bus.valid    = 1'b0;
		pix_in_bus.red_in   = '0;
		pix_in_bus.green_in = '0;
		pix_in_bus.blue_in  = '0;
		pix_out_bus.ready   = 1'b0;
		gain_now            = GAIN_RESET;
		fail_count          = 0;
		cycle_count         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset gain: rails, single bits, mid values
		@(negedge clk);
		pixel_q.push_back(make_pixel(0, 0, 0));
		pixel_q.push_back(make_pixel(255, 255, 255));
		pixel_q.push_back(make_pixel(255, 0, 0));
		pixel_q.push_back(make_pixel(0, 255, 0));
		pixel_q.push_back(make_pixel(0, 0, 255));
		pixel_q.push_back(make_pixel(8'h55, 8'hAA, 8'h55));
		pixel_q.push_back(make_pixel(8'hAA, 8'h55, 8'hAA));
		pixel_q.push_back(make_pixel(1, 1, 1));
		pixel_q.push_back(make_pixel(128, 128, 128));
		pixel_q.push_back(make_pixel(231, 232, 233));
		pixel_q.push_back(make_pixel(100, 150, 200));
		pixel_q.push_back(make_pixel(254, 127, 64));
		queue_set(RANDOM_PER_SET);

		// Zero gain blanks everything
		write_gain('0);
		queue_set(RANDOM_PER_SET);
		write_gain(GAIN_UNITY);
		queue_set(RANDOM_PER_SET);
		write_gain(GAIN_TOP);
		queue_set(RANDOM_PER_SET);
		// Gains above the nominal range go through unchanged
		write_gain(GAIN_FULL);
		queue_set(RANDOM_PER_SET);
		write_gain(15'd1);
		queue_set(RANDOM_PER_SET);
		write_gain(15'd8191);
		queue_set(RANDOM_PER_SET);
		write_gain(GAIN_W'($urandom_range(0, 16384)));
		queue_set(RANDOM_PER_SET);
		write_gain(GAIN_W'($urandom_range(16385, 32767)));
		queue_set(RANDOM_PER_SET);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sepia_q.size() != 0) begin
			$error("%0d result words never arrived", sepia_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
